### design/fpq8_pkg.sv
// ----------------------------------------------------------------------------
// fpq8_pkg
// Shared types and constants for the Q24.8 fixed-point ALU pipeline.
// ----------------------------------------------------------------------------
package fpq8_pkg;

    localparam int FRAC_BITS = 8;
    localparam int DATA_W    = 32;
    // width of the scaled dividend magnitude and of the quotient
    localparam int DIV_W     = DATA_W + FRAC_BITS;

    localparam int IN_W      = 4 + 2 * DATA_W;
    localparam int IN_BYTES  = (IN_W + 7) / 8;
    localparam int OUT_W     = DATA_W + 5;
    localparam int OUT_BYTES = (OUT_W + 7) / 8;

    localparam logic [3:0] OP_ADD  = 4'd0;
    localparam logic [3:0] OP_SUB  = 4'd1;
    localparam logic [3:0] OP_MUL  = 4'd2;
    localparam logic [3:0] OP_DIV  = 4'd3;
    localparam logic [3:0] OP_MIN  = 4'd4;
    localparam logic [3:0] OP_MAX  = 4'd5;
    localparam logic [3:0] OP_INC  = 4'd6;
    localparam logic [3:0] OP_DEC  = 4'd7;
    localparam logic [3:0] OP_ITOF = 4'd8;
    localparam logic [3:0] OP_FTOI = 4'd9;

    typedef struct packed {
        logic [3:0]              op;
        logic                    a_less;
        logic                    a_equal;
        logic                    a_greater;
        logic [DATA_W-1:0]       value;
        logic                    ovf;
        logic signed [63:0]      prod;
        logic [DATA_W-1:0]       rem;
        logic [DIV_W-1:0]        quo;
        logic [DIV_W-1:0]        dvd;
        logic [DATA_W-1:0]       dvs;
        logic                    qneg;
        logic                    zdiv;
    } t_pipe;

    // true when bits [63:31] are all equal, i.e. the value fits 32 signed bits
    function automatic logic fits32(input logic [63:0] v);
        logic [32:0] top;
        top = v[63:31];
        return (top == '0) || (top == '1);
    endfunction

endpackage

### design/fixed_point_q8_alu_unit.sv
// ----------------------------------------------------------------------------
// fixed_point_q8_alu_unit
// Pipelined Q24.8 ALU: add, sub, mul, div, min, max, inc, dec, conversions.
// ----------------------------------------------------------------------------
// input to output passes the stage-0 register, the divider stage registers and the output register
// throughput: one transaction per cycle unless stalled; the restoring divider retires one
//   quotient bit per stage, which sets the pipeline depth
// the whole pipeline holds while the output register is full and not taken
// synchronous active-low reset clears the valid bits only
module fixed_point_q8_alu_unit
    import fpq8_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // op[3:0], operand_a[35:4], operand_b[67:36]
    input  logic [IN_BYTES*8-1:0]  i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // value_out[31:0], a_less, a_equal, a_greater, overflow_flag, zero_divisor
    output logic [OUT_BYTES*8-1:0] o_m_axis_tdata
);

    logic                en;
    logic [DIV_W:0]      r_vld;
    t_pipe               r_pipe [DIV_W+1];
    t_pipe               n_pipe [DIV_W+1];
    t_pipe               n_head;
    logic                r_out_vld;
    logic [OUT_W-1:0]    r_out;
    logic [OUT_W-1:0]    n_out;

    assign en = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = en;

    // stage 0: simple ops, product, divider setup
    always_comb begin
        logic [3:0]               op;
        logic signed [DATA_W-1:0] a, b;
        logic signed [DATA_W:0]   s;
        logic signed [63:0]       sh;
        logic [DATA_W-1:0]        ma, mb;
        op = i_s_axis_tdata[3:0];
        a  = i_s_axis_tdata[DATA_W+3:4];
        b  = i_s_axis_tdata[2*DATA_W+3:DATA_W+4];
        ma = a[DATA_W-1] ? DATA_W'(-a) : DATA_W'(a);
        mb = b[DATA_W-1] ? DATA_W'(-b) : DATA_W'(b);
        s  = '0;
        sh = '0;
        n_head = '0;
        n_head.op        = op;
        n_head.a_less    = a < b;
        n_head.a_equal   = a == b;
        n_head.a_greater = a > b;
        n_head.prod      = 64'(a) * 64'(b);
        n_head.dvd       = {ma, {FRAC_BITS{1'b0}}};
        n_head.dvs       = mb;
        n_head.qneg      = a[DATA_W-1] ^ b[DATA_W-1];
        n_head.zdiv      = (op == OP_DIV) && (b == '0);
        unique case (op)
            OP_ADD: begin
                s = (DATA_W+1)'(a) + (DATA_W+1)'(b);
                n_head.value = s[DATA_W-1:0];
                n_head.ovf   = s[DATA_W] ^ s[DATA_W-1];
            end
            OP_SUB: begin
                s = (DATA_W+1)'(a) - (DATA_W+1)'(b);
                n_head.value = s[DATA_W-1:0];
                n_head.ovf   = s[DATA_W] ^ s[DATA_W-1];
            end
            OP_INC: begin
                s = (DATA_W+1)'(a) + 1;
                n_head.value = s[DATA_W-1:0];
                n_head.ovf   = s[DATA_W] ^ s[DATA_W-1];
            end
            OP_DEC: begin
                s = (DATA_W+1)'(a) - 1;
                n_head.value = s[DATA_W-1:0];
                n_head.ovf   = s[DATA_W] ^ s[DATA_W-1];
            end
            OP_MIN: n_head.value = (a < b) ? a : b;
            OP_MAX: n_head.value = (a > b) ? a : b;
            OP_ITOF: begin
                sh = 64'(a) <<< FRAC_BITS;
                n_head.value = sh[DATA_W-1:0];
                n_head.ovf   = !fits32(sh);
            end
            OP_FTOI: n_head.value = DATA_W'(a >>> FRAC_BITS);
            default: n_head.value = '0;
        endcase
    end

    // stages 1..DIV_W: one divider bit each; stage 1 also scales the product
    always_comb begin
        logic [DATA_W:0]    rs;
        logic               ge;
        logic signed [63:0] t;
        logic signed [63:0] q;
        n_pipe[0] = n_head;
        t = '0;
        q = '0;
        for (int i = 1; i <= DIV_W; i++) begin
            n_pipe[i] = r_pipe[i-1];
            rs = {r_pipe[i-1].rem, r_pipe[i-1].dvd[DIV_W-1]};
            ge = rs >= {1'b0, r_pipe[i-1].dvs};
            n_pipe[i].rem = ge ? DATA_W'(rs - {1'b0, r_pipe[i-1].dvs}) : rs[DATA_W-1:0];
            n_pipe[i].quo = {r_pipe[i-1].quo[DIV_W-2:0], ge};
            n_pipe[i].dvd = r_pipe[i-1].dvd << 1;
            if (i == 1 && r_pipe[0].op == OP_MUL) begin
                // bias negative products so the shift truncates toward zero
                t = r_pipe[0].prod
                    + (r_pipe[0].prod[63] ? ((64'sd1 <<< FRAC_BITS) - 64'sd1) : 64'sd0);
                q = t >>> FRAC_BITS;
                n_pipe[i].value = q[DATA_W-1:0];
                n_pipe[i].ovf   = !fits32(q);
            end
        end
    end

    // output stage: sign the quotient, zero the result on a zero divisor, pack the flags
    always_comb begin
        t_pipe       p;
        logic [63:0] qs;
        logic [DATA_W-1:0] v;
        logic        o;
        p  = r_pipe[DIV_W];
        qs = p.qneg ? -64'(p.quo) : 64'(p.quo);
        v  = p.value;
        o  = p.ovf;
        if (p.op == OP_DIV) begin
            if (p.zdiv) begin
                v = '0;
                o = 1'b0;
            end else begin
                v = qs[DATA_W-1:0];
                o = !fits32(qs);
            end
        end
        n_out = {p.zdiv, o, p.a_greater, p.a_equal, p.a_less, v};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld     <= {r_vld[DIV_W-1:0], i_s_axis_tvalid};
            r_out_vld <= r_vld[DIV_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i <= DIV_W; i++) begin
                r_pipe[i] <= n_pipe[i];
            end
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = (OUT_BYTES*8)'(r_out);

endmodule

### design/fpq8_checker.sv
// ----------------------------------------------------------------------------
// fpq8_checker
// Port-level checks for the fixed-point ALU, bound to the top level.
// ----------------------------------------------------------------------------
module fpq8_checker
    import fpq8_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_axis_tvalid,
    input logic                   o_s_axis_tready,
    input logic [IN_BYTES*8-1:0]  i_s_axis_tdata,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_BYTES*8-1:0] o_m_axis_tdata
);

    // a stalled output transaction holds its data
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output changed while stalled");

    // the input side is held only by a stalled full output
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready == (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("ready does not follow output stall");

    // exactly one comparison flag
    a_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> $onehot(o_m_axis_tdata[DATA_W+2:DATA_W]))
        else $error("comparison flags not one-hot");

    // divide by zero gives zero and no overflow
    a_zdiv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[DATA_W+4]
            |-> o_m_axis_tdata[DATA_W-1:0] == '0 && !o_m_axis_tdata[DATA_W+3])
        else $error("zero divisor result malformed");

endmodule

bind fixed_point_q8_alu_unit fpq8_checker u_fpq8_checker (.*);

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stream-level check of the Q24.8 ALU: directed corner operands, then random
// operations with random source gaps and sink stalls, scored in order.
// ----------------------------------------------------------------------------
module tb
    import fpq8_pkg::*;
();

    localparam int LATENCY = DIV_W + 2;
    localparam int N_RAND  = 1700;

    // packed from the top down: value sits in the low bits
    typedef struct packed {
        logic        zdiv;
        logic        ovf;
        logic        gt;
        logic        eq;
        logic        lt;
        logic [31:0] value;
    } t_alu_res;

    class t_alu_scoreboard;
        t_alu_res pending_q[$];
        int       n_err;

        function t_alu_res compute(logic [3:0] op, logic signed [31:0] a,
                                   logic signed [31:0] b);
            t_alu_res r;
            logic signed [63:0] wa, wb, full;
            logic use_full;
            wa = a;
            wb = b;
            full = '0;
            use_full = 1'b1;
            r = '0;
            case (op)
                OP_ADD:  full = wa + wb;
                OP_SUB:  full = wa - wb;
                OP_MUL:  full = (wa * wb) / 64'sd256;
                OP_DIV: begin
                    if (b == 0) r.zdiv = 1'b1;
                    else full = (wa * 64'sd256) / wb;
                end
                OP_MIN:  full = (wa < wb) ? wa : wb;
                OP_MAX:  full = (wa > wb) ? wa : wb;
                OP_INC:  full = wa + 1;
                OP_DEC:  full = wa - 1;
                OP_ITOF: full = wa * 64'sd256;
                OP_FTOI: begin
                    use_full = 1'b0;
                    r.value = a >>> FRAC_BITS;
                end
                default: full = '0;
            endcase
            if (use_full) begin
                r.value = full[31:0];
                r.ovf = (full > 64'sh7fffffff) || (full < -64'sh80000000);
            end
            r.lt = a < b;
            r.eq = a == b;
            r.gt = a > b;
            return r;
        endfunction

        function void note_operation(logic [3:0] op, logic [31:0] a, logic [31:0] b);
            pending_q.push_back(compute(op, a, b));
        endfunction

        function void check_result(logic [OUT_BYTES*8-1:0] d);
            t_alu_res got, want;
            got = d[OUT_W-1:0];
            if (pending_q.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected result %h", got);
                return;
            end
            want = pending_q.pop_front();
            if (got !== want) begin
                n_err++;
                if (n_err <= 10)
                    $display({"mismatch: value exp %h got %h, lt/eq/gt exp %b%b%b got %b%b%b,",
                              " ovf exp %b got %b, zdiv exp %b got %b"},
                             want.value, got.value, want.lt, want.eq, want.gt,
                             got.lt, got.eq, got.gt, want.ovf, got.ovf, want.zdiv, got.zdiv);
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_tvalid, s_tready;
    logic [IN_BYTES*8-1:0]  s_tdata;
    logic                   m_tvalid, m_tready;
    logic [OUT_BYTES*8-1:0] m_tdata;
    logic                   src_done;
    t_alu_scoreboard        sb;

    fixed_point_q8_alu_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_operation(logic [3:0] op, logic [31:0] a, logic [31:0] b);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tdata  <= (IN_BYTES*8)'({b, a, op});
        s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sb.note_operation(op, a, b);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($signed($urandom_range(0, 1023)) - 512);
            3: return {16'(($urandom_range(0, 1)) ? 16'hffff : 16'h0), 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    // sink may hold ready low for a randomly drawn wait before taking each transaction
    initial begin
        int wait_cyc;
        m_tready = 1'b0;
        forever begin
            wait_cyc = $urandom_range(0, 4);
            if (wait_cyc != 0) begin
                m_tready <= 1'b0;
                repeat (wait_cyc) @(negedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!(i_rst_n && m_tvalid)) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && m_tvalid && m_tready) sb.check_result(m_tdata);

    initial begin
        logic [31:0] corner [6];
        logic [3:0] op;
        sb = new();
        s_tvalid = 1'b0;
        s_tdata  = '0;
        i_rst_n  = 1'b0;
        src_done = 1'b0;
        corner = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h100, 32'hffff_ff00};
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // every operation on extreme operands, divide by zero, unused opcodes
        for (int k = 0; k < 16; k++)
            send_operation(4'(k), corner[k % 6], corner[(k + 1) % 6]);
        send_operation(OP_DIV, 32'h7fff_ffff, 32'h0);
        send_operation(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
        send_operation(OP_MUL, 32'h8000_0000, 32'h8000_0000);
        send_operation(OP_FTOI, 32'hffff_ff01, 32'h0);
        send_operation(OP_MUL, 32'hffff_ff01, 32'h1);
        send_operation(OP_INC, 32'h7fff_ffff, 32'h7fff_ffff);
        send_operation(OP_DEC, 32'h8000_0000, 32'h1);

        for (int n = 0; n < N_RAND; n++) begin
            if (n == N_RAND / 2) begin
                // drain fully before carrying on
                s_tvalid <= 1'b0;
                @(negedge i_clk);
                while (sb.pending_q.size() != 0) @(negedge i_clk);
            end
            op = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(10, 15))
                                              : 4'($urandom_range(0, 9));
            if ($urandom_range(0, 9) == 0)
                send_operation(op, pick_operand(), ($urandom_range(0, 1)) ? 32'h0 : 32'h1);
            else begin
                logic [31:0] x;
                x = pick_operand();
                send_operation(op, x, ($urandom_range(0, 7) == 0) ? x : pick_operand());
            end
        end
        s_tvalid <= 1'b0;
        src_done = 1'b1;
    end

    initial begin
        wait (src_done);
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (sb.n_err == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #200000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
